/* rtl/core/loic_pkg.sv */
// Shared types, codes and default sizes of the lock-order inversion checker.
package loic_pkg;

  localparam int OP_W      = 2;
  localparam int TH_W      = 2;
  localparam int ID_W      = 5;
  localparam int VERDICT_W = 3;

  localparam int MAX_LOCKS_DEF  = 32;
  localparam int THREADS_DEF    = 4;
  localparam int HELD_DEPTH_DEF = 8;

  localparam logic [OP_W-1:0] OP_CREATE  = 2'd0;
  localparam logic [OP_W-1:0] OP_LOCK    = 2'd1;
  localparam logic [OP_W-1:0] OP_UNLOCK  = 2'd2;
  localparam logic [OP_W-1:0] OP_DESTROY = 2'd3;

  localparam logic [VERDICT_W-1:0] V_OK        = 3'd0;
  localparam logic [VERDICT_W-1:0] V_RECURSIVE = 3'd1;
  localparam logic [VERDICT_W-1:0] V_INVERSION = 3'd2;
  localparam logic [VERDICT_W-1:0] V_NO_FREE   = 3'd3;
  localparam logic [VERDICT_W-1:0] V_LIST_FULL = 3'd4;

  typedef struct packed {
    logic load;
    logic cr_pop;
    logic cr_fresh;
    logic cr_none;
    logic ds_push;
    logic sweep;
    logic lk_start;
    logic lk_row;
    logic lk_other;
    logic lk_check;
    logic lk_end;
    logic ul_start;
    logic ul_prev;
    logic ul_next;
    logic ul_shift;
    logic ul_done;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            id_ok;
    logic            th_ok;
    logic            free_nz;
    logic            fresh_ok;
    logic            cnt_zero;
    logic            hit;
    logic            idx_last;
    logic            idx_zero;
    logic            ul_match;
    logic            sw_done;
  } status_t;

endpackage

/* rtl/core/lock_order_inversion_checker.sv */
// Top level of the lock-order inversion checker.
//
//   Channel   Handshake          Payload
//   command   start / busy       operation, thread_id, lock_id
//   result    done (one cycle)   assigned_id, verdict, partner_id
//
// An item is taken when start is high and busy is low; for a create from the free
// stack or an operation that does nothing, the dispatch state registers done.
// Create of a fresh id and destroy sweep the order matrix column, one row a cycle.
// Lock walks the thread's held list entry by entry until a hit or its end; unlock
// searches the list from its last entry and shifts the entries after the match down.
// Reset is synchronous and clears the counts and the row valid bits at once.
// The receiver cannot stall: each result is shown for exactly one cycle.
module lock_order_inversion_checker import loic_pkg::*; #(
  parameter int MAX_LOCKS  = MAX_LOCKS_DEF,
  parameter int THREADS    = THREADS_DEF,
  parameter int HELD_DEPTH = HELD_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [OP_W-1:0]      operation,
  input  logic [TH_W-1:0]      thread_id,
  input  logic [ID_W-1:0]      lock_id,
  output logic                 done,
  output logic [ID_W-1:0]      assigned_id,
  output logic [VERDICT_W-1:0] verdict,
  output logic [ID_W-1:0]      partner_id
);

  cmd_t    cmd;
  status_t st;

  loic_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .st    (st),
    .cmd   (cmd),
    .busy  (busy)
  );

  loic_datapath #(
    .MAX_LOCKS  (MAX_LOCKS),
    .THREADS    (THREADS),
    .HELD_DEPTH (HELD_DEPTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .st          (st),
    .operation   (operation),
    .thread_id   (thread_id),
    .lock_id     (lock_id),
    .assigned_id (assigned_id),
    .verdict     (verdict),
    .partner_id  (partner_id),
    .done        (done)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("item accepted but the block did not go busy");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while an item is still at work");

  a_partner_zero: assert property (@(posedge clk) disable iff (rst)
    (done && verdict != V_RECURSIVE && verdict != V_INVERSION) |-> (partner_id == '0))
    else $error("partner id set without a detected inversion");

endmodule

/* rtl/core/loic_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
module loic_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/loic_ctrl.sv */
// Controller state machine of the lock-order inversion checker.
module loic_ctrl import loic_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  status_t st,
  output cmd_t    cmd,
  output logic    busy
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DISPATCH = 4'd1;
  localparam logic [3:0] S_SWEEP    = 4'd2;
  localparam logic [3:0] S_LK_ROW   = 4'd3;
  localparam logic [3:0] S_LK_RD    = 4'd4;
  localparam logic [3:0] S_LK_OTH   = 4'd5;
  localparam logic [3:0] S_LK_CHK   = 4'd6;
  localparam logic [3:0] S_LK_END   = 4'd7;
  localparam logic [3:0] S_UL_RD    = 4'd8;
  localparam logic [3:0] S_UL_CMP   = 4'd9;
  localparam logic [3:0] S_UL_SH_RD = 4'd10;
  localparam logic [3:0] S_UL_SH_WR = 4'd11;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_next = S_IDLE;
        unique case (st.op)
          OP_CREATE: begin
            if (st.free_nz) begin
              cmd.cr_pop = 1'b1;
              cmd.finish = 1'b1;
            end else if (st.fresh_ok) begin
              cmd.cr_fresh = 1'b1;
              state_next   = S_SWEEP;
            end else begin
              cmd.cr_none = 1'b1;
              cmd.finish  = 1'b1;
            end
          end
          OP_DESTROY: begin
            if (st.id_ok) begin
              cmd.ds_push = 1'b1;
              state_next  = S_SWEEP;
            end else begin
              cmd.finish = 1'b1;
            end
          end
          OP_LOCK: begin
            if (st.id_ok && st.th_ok) begin
              cmd.lk_start = 1'b1;
              state_next   = S_LK_ROW;
            end else begin
              cmd.finish = 1'b1;
            end
          end
          OP_UNLOCK: begin
            if (st.id_ok && st.th_ok && !st.cnt_zero) begin
              cmd.ul_start = 1'b1;
              state_next   = S_UL_RD;
            end else begin
              cmd.finish = 1'b1;
            end
          end
          default: begin
            cmd.finish = 1'b1;
          end
        endcase
      end
      S_SWEEP: begin
        cmd.sweep = 1'b1;
        if (st.sw_done) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_LK_ROW: begin
        cmd.lk_row = 1'b1;
        state_next = st.cnt_zero ? S_LK_END : S_LK_OTH;
      end
      S_LK_RD: begin
        state_next = S_LK_OTH;
      end
      S_LK_OTH: begin
        cmd.lk_other = 1'b1;
        state_next   = S_LK_CHK;
      end
      S_LK_CHK: begin
        cmd.lk_check = 1'b1;
        state_next   = (st.hit || st.idx_last) ? S_LK_END : S_LK_RD;
      end
      S_LK_END: begin
        cmd.lk_end = 1'b1;
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      S_UL_RD: begin
        state_next = S_UL_CMP;
      end
      S_UL_CMP: begin
        if (st.ul_match) begin
          if (st.idx_last) begin
            cmd.ul_done = 1'b1;
            cmd.finish  = 1'b1;
            state_next  = S_IDLE;
          end else begin
            cmd.ul_next = 1'b1;
            state_next  = S_UL_SH_RD;
          end
        end else if (st.idx_zero) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.ul_prev = 1'b1;
          state_next  = S_UL_RD;
        end
      end
      S_UL_SH_RD: begin
        state_next = S_UL_SH_WR;
      end
      S_UL_SH_WR: begin
        cmd.ul_shift = 1'b1;
        if (st.idx_last) begin
          cmd.ul_done = 1'b1;
          cmd.finish  = 1'b1;
          state_next  = S_IDLE;
        end else begin
          state_next = S_UL_SH_RD;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* rtl/core/loic_datapath.sv */
// Datapath of the lock-order inversion checker: order matrix, free stack and held lists.
module loic_datapath import loic_pkg::*; #(
  parameter int MAX_LOCKS  = MAX_LOCKS_DEF,
  parameter int THREADS    = THREADS_DEF,
  parameter int HELD_DEPTH = HELD_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cmd_t                 cmd,
  output status_t              st,
  input  logic [OP_W-1:0]      operation,
  input  logic [TH_W-1:0]      thread_id,
  input  logic [ID_W-1:0]      lock_id,
  output logic [ID_W-1:0]      assigned_id,
  output logic [VERDICT_W-1:0] verdict,
  output logic [ID_W-1:0]      partner_id,
  output logic                 done
);

  localparam int IW     = $clog2(MAX_LOCKS);
  localparam int NW     = $clog2(MAX_LOCKS + 1);
  localparam int TW     = (THREADS > 1) ? $clog2(THREADS) : 1;
  localparam int CW     = $clog2(HELD_DEPTH + 1);
  localparam int HDEPTH = THREADS * HELD_DEPTH;
  localparam int HAW    = (HDEPTH > 1) ? $clog2(HDEPTH) : 1;
  localparam logic [MAX_LOCKS-1:0] ONE_BIT = {{(MAX_LOCKS - 1){1'b0}}, 1'b1};

  logic [OP_W-1:0]      op_r;
  logic [TW-1:0]        th_r;
  logic [IW-1:0]        id_r;
  logic                 id_ok_r;
  logic                 th_ok_r;
  logic [MAX_LOCKS-1:0] valid;
  logic [NW-1:0]        free_count;
  logic [NW-1:0]        fresh_count;
  logic [CW-1:0]        held_count [THREADS];
  logic [MAX_LOCKS-1:0] row_reg;
  logic [IW-1:0]        other_r;
  logic [CW-1:0]        idx;
  logic                 hit_r;
  logic [IW-1:0]        col_r;
  logic [NW-1:0]        sw;
  logic [IW-1:0]        assigned_r;
  logic [VERDICT_W-1:0] verdict_r;
  logic [IW-1:0]        partner_r;
  logic                 done_r;

  logic                 mx_we;
  logic [IW-1:0]        mx_waddr;
  logic [MAX_LOCKS-1:0] mx_wdata;
  logic [IW-1:0]        mx_raddr;
  logic [MAX_LOCKS-1:0] mx_rdata;
  logic                 fs_we;
  logic [IW-1:0]        fs_waddr;
  logic [IW-1:0]        fs_raddr;
  logic [IW-1:0]        fs_rdata;
  logic                 hl_we;
  logic [HAW-1:0]       hl_waddr;
  logic [IW-1:0]        hl_wdata;
  logic [HAW-1:0]       hl_raddr;
  logic [IW-1:0]        hl_rdata;

  logic [CW-1:0]        cnt;
  logic                 cnt_room;
  logic [HAW-1:0]       base;
  logic [MAX_LOCKS-1:0] other_row;
  logic                 fwd;
  logic                 rev;
  logic                 hit;

  assign cnt       = held_count[th_r];
  assign cnt_room  = (cnt < CW'(HELD_DEPTH));
  assign base      = HAW'(th_r) * HAW'(HELD_DEPTH);
  assign other_row = valid[other_r] ? mx_rdata : '0;
  assign fwd       = row_reg[other_r];
  assign rev       = (other_r == id_r) || other_row[id_r];
  assign hit       = !fwd && rev;

  assign mx_raddr = cmd.lk_other ? hl_rdata : (cmd.sweep ? IW'(sw) : id_r);
  assign mx_we    = (cmd.sweep && (sw != '0)) || cmd.lk_end;
  assign mx_waddr = cmd.lk_end ? id_r : IW'(sw - 1'b1);
  assign mx_wdata = cmd.lk_end ? row_reg : (mx_rdata & ~(ONE_BIT << col_r));

  assign fs_raddr = IW'(free_count - 1'b1);
  assign fs_we    = cmd.ds_push && (free_count < NW'(MAX_LOCKS));
  assign fs_waddr = IW'(free_count);

  assign hl_raddr = base + HAW'(idx);
  assign hl_we    = (cmd.lk_end && !hit_r && cnt_room) || cmd.ul_shift;
  assign hl_waddr = cmd.ul_shift ? (base + HAW'(idx - 1'b1)) : (base + HAW'(cnt));
  assign hl_wdata = cmd.ul_shift ? hl_rdata : id_r;

  loic_ram #(.WIDTH(MAX_LOCKS), .DEPTH(MAX_LOCKS)) u_matrix (
    .clk   (clk),
    .we    (mx_we),
    .waddr (mx_waddr),
    .wdata (mx_wdata),
    .raddr (mx_raddr),
    .rdata (mx_rdata)
  );

  loic_ram #(.WIDTH(IW), .DEPTH(MAX_LOCKS)) u_free_stack (
    .clk   (clk),
    .we    (fs_we),
    .waddr (fs_waddr),
    .wdata (id_r),
    .raddr (fs_raddr),
    .rdata (fs_rdata)
  );

  loic_ram #(.WIDTH(IW), .DEPTH(HDEPTH)) u_held (
    .clk   (clk),
    .we    (hl_we),
    .waddr (hl_waddr),
    .wdata (hl_wdata),
    .raddr (hl_raddr),
    .rdata (hl_rdata)
  );

  always_comb begin
    st.op       = op_r;
    st.id_ok    = id_ok_r;
    st.th_ok    = th_ok_r;
    st.free_nz  = (free_count != '0);
    st.fresh_ok = (fresh_count < NW'(MAX_LOCKS));
    st.cnt_zero = (cnt == '0);
    st.hit      = hit;
    st.idx_last = (({1'b0, idx} + 1'b1) == {1'b0, cnt});
    st.idx_zero = (idx == '0);
    st.ul_match = (hl_rdata == id_r);
    st.sw_done  = (sw == NW'(MAX_LOCKS));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid       <= '0;
      free_count  <= '0;
      fresh_count <= '0;
      done_r      <= 1'b0;
      for (int t = 0; t < THREADS; t++) begin
        held_count[t] <= '0;
      end
    end else begin
      done_r <= cmd.finish;
      if (cmd.cr_pop) begin
        valid[fs_rdata] <= 1'b0;
        free_count      <= free_count - 1'b1;
      end
      if (cmd.cr_fresh) begin
        valid[IW'(fresh_count)] <= 1'b0;
        fresh_count             <= fresh_count + 1'b1;
      end
      if (fs_we) begin
        free_count <= free_count + 1'b1;
      end
      if (cmd.lk_end) begin
        valid[id_r] <= 1'b1;
        if (!hit_r && cnt_room) begin
          held_count[th_r] <= cnt + 1'b1;
        end
      end
      if (cmd.ul_done) begin
        held_count[th_r] <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r       <= operation;
      th_r       <= TW'(thread_id);
      id_r       <= IW'(lock_id);
      id_ok_r    <= (int'(lock_id) < MAX_LOCKS);
      th_ok_r    <= (int'(thread_id) < THREADS);
      assigned_r <= '0;
      verdict_r  <= V_OK;
      partner_r  <= '0;
    end
    if (cmd.cr_pop) begin
      assigned_r <= fs_rdata;
    end
    if (cmd.cr_fresh) begin
      assigned_r <= IW'(fresh_count);
      col_r      <= IW'(fresh_count);
      sw         <= '0;
    end
    if (cmd.cr_none) begin
      verdict_r <= V_NO_FREE;
    end
    if (cmd.ds_push) begin
      col_r <= id_r;
      sw    <= '0;
    end
    if (cmd.sweep) begin
      sw <= sw + 1'b1;
    end
    if (cmd.lk_start) begin
      idx   <= '0;
      hit_r <= 1'b0;
    end
    if (cmd.lk_row) begin
      row_reg <= valid[id_r] ? mx_rdata : '0;
    end
    if (cmd.lk_other) begin
      other_r <= hl_rdata;
    end
    if (cmd.lk_check) begin
      idx <= idx + 1'b1;
      if (!fwd) begin
        row_reg[other_r] <= 1'b1;
      end
      if (hit) begin
        hit_r     <= 1'b1;
        verdict_r <= (other_r == id_r) ? V_RECURSIVE : V_INVERSION;
        partner_r <= other_r;
      end
    end
    if (cmd.lk_end && !hit_r && !cnt_room) begin
      verdict_r <= V_LIST_FULL;
    end
    if (cmd.ul_start) begin
      idx <= cnt - 1'b1;
    end
    if (cmd.ul_prev) begin
      idx <= idx - 1'b1;
    end
    if (cmd.ul_next || cmd.ul_shift) begin
      idx <= idx + 1'b1;
    end
  end

  assign assigned_id = ID_W'(assigned_r);
  assign verdict     = verdict_r;
  assign partner_id  = ID_W'(partner_r);
  assign done        = done_r;

endmodule
